// ===== sv/sps_pkg.sv =====
// Shared types and constants for the sandpile stabilizer.
package sps_pkg;

   localparam int GRID_SIDE_DEF = 257;
   localparam int HEIGHT_W = 16;
   localparam int ODO_W = 48;
   localparam int RADIUS_W = 8;
   localparam logic [RADIUS_W-1:0] RADIUS_MAX = 8'hFF;
   localparam logic [HEIGHT_W-1:0] HEIGHT_MAX = 16'hFFFF;
   localparam logic [HEIGHT_W-1:0] BACKGROUND_GRAINS = 16'd2;
   localparam int TOPPLE_QUANTUM = 4;

   localparam logic ACTION_ADD = 1'b0;
   localparam logic ACTION_CLEAR = 1'b1;

   // Datapath command from the controller.
   typedef enum logic [3:0] {
      CMD_NONE,
      CMD_CLEAR_STEP,   // write background into one site, advance sweep
      CMD_DROP_READ,    // read a drop site
      CMD_DROP_WRITE,   // add grains, push if unstable
      CMD_POP,          // pop stack top, read its entry
      CMD_TOPPLE,       // update popped site and odometer
      CMD_NB_READ,      // read the current neighbor
      CMD_NB_WRITE,     // add amount to neighbor, push if unstable
      CMD_SELF_READ,    // read the popped site
      CMD_SELF_PUSH,    // push popped site if still unstable
      CMD_OUT_READ      // read odometers at the two lower sites
   } cmd_type;

   typedef struct packed {
      cmd_type    cmd;
      logic [1:0] sel;   // drop site (0 A, 1 B) or neighbor (0 up,1 down,2 left,3 right)
      logic [3:0] grains;
   } ctl_type;

   typedef struct packed {
      logic clear_done;
      logic stack_empty;
      logic nb_valid;    // selected neighbor lies on the lattice
      logic amount_zero; // popped site holds fewer than four grains
      logic out_ready;
   } sts_type;

endpackage

// ===== sv/sandpile_stabilizer_with_odometer.sv =====
// Top level of the sandpile stabilizer with per-site odometers.
//
// Requests arrive on req_* (tdata: action, grains_a, grains_b); one result
// leaves on rsp_* per request. A request is taken only when the block is
// idle, one at a time; the next request is taken the cycle after the
// result leaves.
// An add request drops grains at the two upper centre sites and topples
// sites off a LIFO work stack. Each toppled site goes through pop, load,
// read, update, four neighbor read/write pairs, reread, self push and
// empty test; a site with under four grains stops after one neighbor read.
// A clear request sweeps the whole store, all GRID_SIDE*GRID_SIDE sites
// (66049 at the default), one site per cycle.
// After reset the same sweep runs before the first request is taken.
// A result is held on rsp_* until taken; no request is accepted meanwhile.
// The odometers wrap at 2^48; edge_error stays set until a clear.
module sandpile_stabilizer_with_odometer #(
   parameter int GRID_SIDE = sps_pkg::GRID_SIDE_DEF
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   input  logic [15:0]   req_tdata,   // action[0], grains_a[4:1], grains_b[8:5]
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   output logic [111:0]  rsp_tdata    // odometer_c[47:0], odometer_d[95:48],
                                      // spread_radius[103:96], edge_error[104]
);
   sps_pkg::ctl_type ctl;
   sps_pkg::sts_type sts;
   logic [sps_pkg::ODO_W-1:0]    odo_c, odo_d;
   logic [sps_pkg::RADIUS_W-1:0] radius;
   logic                         border;

   sps_controller u_ctrl (
      .clock, .reset, .req_tvalid, .req_tready, .req_tdata(req_tdata[8:0]),
      .rsp_tvalid, .rsp_tready, .ctl, .sts
   );

   sps_datapath #(.GRID_SIDE(GRID_SIDE)) u_dp (
      .clock, .reset, .ctl, .sts, .odo_c, .odo_d, .radius, .border
   );

   assign rsp_tdata = {7'd0, border, radius, odo_d, odo_c};
endmodule

// ===== sv/sps_datapath.sv =====
// Grid stores, work stack and toppling arithmetic.
module sps_datapath #(
   parameter int GRID_SIDE = sps_pkg::GRID_SIDE_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  sps_pkg::ctl_type              ctl,
   output sps_pkg::sts_type              sts,
   output logic [sps_pkg::ODO_W-1:0]     odo_c,
   output logic [sps_pkg::ODO_W-1:0]     odo_d,
   output logic [sps_pkg::RADIUS_W-1:0]  radius,
   output logic                          border
);
   localparam int CELLS = GRID_SIDE * GRID_SIDE;
   localparam int AW = $clog2(CELLS);
   localparam int CW = $clog2(GRID_SIDE);
   localparam int SW = $clog2(CELLS + 1);
   localparam int CTR = GRID_SIDE / 2;
   localparam logic [AW-1:0] SITE_A = AW'(CTR * GRID_SIDE + CTR);
   localparam logic [AW-1:0] SITE_B = AW'(CTR * GRID_SIDE + CTR + 1);
   localparam logic [AW-1:0] SITE_D = AW'((CTR + 1) * GRID_SIDE + CTR);
   localparam logic [AW-1:0] SITE_C = AW'((CTR + 1) * GRID_SIDE + CTR + 1);
   localparam logic [CW-1:0] CTR_C = CW'(CTR);
   localparam logic [CW-1:0] LAST = CW'(GRID_SIDE - 1);
   localparam int HW = sps_pkg::HEIGHT_W;
   localparam int OW = sps_pkg::ODO_W;

   // Site stores: height, odometer, queued mark; LIFO of sites with row/col.
   logic [HW-1:0]      height_mem [CELLS];
   logic [OW-1:0]      odo_mem    [CELLS];
   logic               mark_mem   [CELLS];
   logic [AW+2*CW-1:0] stack_mem  [CELLS];

   logic [SW-1:0]       sp_ff, sp_in;
   logic [AW-1:0]       sweep_ff, sweep_in;
   logic                clear_done_ff, clear_done_in;
   logic [AW-1:0]       site_ff, site_in;     // popped site
   logic [CW-1:0]       row_ff, row_in, col_ff, col_in;
   logic [HW-1:0]       amount_ff, amount_in;
   logic [sps_pkg::RADIUS_W-1:0] radius_ff, radius_in;
   logic                border_ff, border_in;
   logic                out_ready_ff, out_ready_in;

   // Registered read data.
   logic [HW-1:0]       h_rd_ff;
   logic [OW-1:0]       o_rd_ff;
   logic                m_rd_ff;
   logic [AW+2*CW-1:0]  s_rd_ff;
   logic [OW-1:0]       odo_c_ff, odo_d_ff;

   // Address of the site this command touches.
   logic [AW-1:0]       addr;
   logic [CW-1:0]       nb_row, nb_col;
   logic                nb_ok;
   always_comb begin
      nb_row = row_ff;
      nb_col = col_ff;
      nb_ok  = 1'b1;
      addr   = site_ff;
      case (ctl.sel)
         2'd0: begin
            nb_ok = (row_ff != '0);
            nb_row = row_ff - CW'(1);
            addr = site_ff - AW'(GRID_SIDE);
         end
         2'd1: begin
            nb_ok = (row_ff != LAST);
            nb_row = row_ff + CW'(1);
            addr = site_ff + AW'(GRID_SIDE);
         end
         2'd2: begin
            nb_ok = (col_ff != '0);
            nb_col = col_ff - CW'(1);
            addr = site_ff - AW'(1);
         end
         default: begin
            nb_ok = (col_ff != LAST);
            nb_col = col_ff + CW'(1);
            addr = site_ff + AW'(1);
         end
      endcase
      case (ctl.cmd)
         sps_pkg::CMD_CLEAR_STEP: addr = sweep_ff;
         sps_pkg::CMD_DROP_READ, sps_pkg::CMD_DROP_WRITE:
            addr = (ctl.sel == 2'd0) ? SITE_A : SITE_B;
         sps_pkg::CMD_NB_READ, sps_pkg::CMD_NB_WRITE: ;
         sps_pkg::CMD_OUT_READ: addr = SITE_C;
         default: addr = site_ff;
      endcase
   end

   // Row/col of the drop sites and the pushed site.
   logic [CW-1:0] push_row, push_col;
   always_comb begin
      push_row = CTR_C;
      push_col = (ctl.sel == 2'd0) ? CTR_C : CTR_C + CW'(1);
      if (ctl.cmd == sps_pkg::CMD_NB_WRITE) begin
         push_row = nb_row;
         push_col = nb_col;
      end else if (ctl.cmd == sps_pkg::CMD_SELF_PUSH) begin
         push_row = row_ff;
         push_col = col_ff;
      end
   end

   // Height after adding grains, saturated.
   logic [HW:0]   add_sum;
   logic [HW-1:0] add_h, add_val;
   always_comb begin
      add_val = (ctl.cmd == sps_pkg::CMD_DROP_WRITE) ? HW'(ctl.grains) : amount_ff;
      add_sum = {1'b0, h_rd_ff} + {1'b0, add_val};
      add_h = add_sum[HW] ? sps_pkg::HEIGHT_MAX : add_sum[HW-1:0];
   end

   // Chebyshev radius of the popped site.
   logic [CW-1:0] dr, dc, dmax;
   always_comb begin
      dr = (row_ff > CTR_C) ? row_ff - CTR_C : CTR_C - row_ff;
      dc = (col_ff > CTR_C) ? col_ff - CTR_C : CTR_C - col_ff;
      dmax = (dc > dr) ? dc : dr;
   end
   logic [sps_pkg::RADIUS_W-1:0] r_sat;
   always_comb begin
      if (CW > sps_pkg::RADIUS_W && (dmax >> sps_pkg::RADIUS_W) != '0)
         r_sat = sps_pkg::RADIUS_MAX;
      else
         r_sat = sps_pkg::RADIUS_W'(dmax);
   end

   // Push only unstable, unmarked sites on the lattice while the stack has room.
   logic do_push;
   always_comb begin
      do_push = 1'b0;
      case (ctl.cmd)
         sps_pkg::CMD_DROP_WRITE, sps_pkg::CMD_NB_WRITE:
            do_push = (add_h >= HW'(sps_pkg::TOPPLE_QUANTUM)) && !m_rd_ff &&
                      (sp_ff < SW'(CELLS)) &&
                      (ctl.cmd == sps_pkg::CMD_DROP_WRITE || nb_ok);
         sps_pkg::CMD_SELF_PUSH:
            do_push = (h_rd_ff >= HW'(sps_pkg::TOPPLE_QUANTUM)) && !m_rd_ff &&
                      (sp_ff < SW'(CELLS));
         default: do_push = 1'b0;
      endcase
   end

   // Memory access.
   always_ff @(posedge clock) begin
      h_rd_ff <= height_mem[addr];
      o_rd_ff <= odo_mem[addr];
      m_rd_ff <= mark_mem[addr];
      s_rd_ff <= stack_mem[AW'(sp_ff - SW'(1))];
      case (ctl.cmd)
         sps_pkg::CMD_CLEAR_STEP: begin
            height_mem[addr] <= (addr == SITE_C || addr == SITE_D) ?
                                sps_pkg::BACKGROUND_GRAINS : '0;
            odo_mem[addr] <= '0;
            mark_mem[addr] <= 1'b0;
         end
         sps_pkg::CMD_DROP_WRITE, sps_pkg::CMD_NB_WRITE: begin
            if (ctl.cmd == sps_pkg::CMD_DROP_WRITE || nb_ok)
               height_mem[addr] <= add_h;
            if (do_push) mark_mem[addr] <= 1'b1;
         end
         sps_pkg::CMD_TOPPLE: begin
            mark_mem[addr] <= 1'b0;
            height_mem[addr] <= {14'd0, h_rd_ff[1:0]};
            odo_mem[addr] <= o_rd_ff + OW'(amount_in);
         end
         sps_pkg::CMD_SELF_PUSH: begin
            if (do_push) mark_mem[addr] <= 1'b1;
         end
         default: ;
      endcase
      if (do_push)
         stack_mem[AW'(sp_ff)] <= {addr, push_row, push_col};
      if (ctl.cmd == sps_pkg::CMD_OUT_READ) begin
         odo_c_ff <= odo_mem[addr];
         odo_d_ff <= odo_mem[SITE_D];
      end
   end

   // Control registers.
   always_comb begin
      sp_in = sp_ff;
      sweep_in = sweep_ff;
      clear_done_in = 1'b0;
      site_in = site_ff;
      row_in = row_ff;
      col_in = col_ff;
      amount_in = amount_ff;
      radius_in = radius_ff;
      border_in = border_ff;
      out_ready_in = (ctl.cmd == sps_pkg::CMD_OUT_READ);
      case (ctl.cmd)
         sps_pkg::CMD_CLEAR_STEP: begin
            sp_in = '0;
            radius_in = '0;
            border_in = 1'b0;
            if (sweep_ff == AW'(CELLS - 1)) begin
               sweep_in = '0;
               clear_done_in = 1'b1;
            end else begin
               sweep_in = sweep_ff + AW'(1);
            end
         end
         sps_pkg::CMD_POP: sp_in = sp_ff - SW'(1);
         sps_pkg::CMD_TOPPLE: begin
            amount_in = {2'b00, h_rd_ff[HW-1:2]};
            if (amount_in != '0) begin
               if (row_ff == '0 || row_ff == LAST || col_ff == '0 || col_ff == LAST)
                  border_in = 1'b1;
               if (r_sat > radius_ff) radius_in = r_sat;
            end
         end
         default: ;
      endcase
      if (ctl.cmd == sps_pkg::CMD_TOPPLE && h_rd_ff[HW-1:2] == '0)
         amount_in = '0;
      if (do_push) sp_in = sp_ff + SW'(1);
   end

   // Latch popped entry in the cycle after the pop read.
   logic pop_d_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         sp_ff <= '0;
         sweep_ff <= '0;
         clear_done_ff <= 1'b0;
         radius_ff <= '0;
         border_ff <= 1'b0;
         out_ready_ff <= 1'b0;
         pop_d_ff <= 1'b0;
      end else begin
         sp_ff <= sp_in;
         sweep_ff <= sweep_in;
         clear_done_ff <= clear_done_in;
         radius_ff <= radius_in;
         border_ff <= border_in;
         out_ready_ff <= out_ready_in;
         pop_d_ff <= (ctl.cmd == sps_pkg::CMD_POP);
      end
      amount_ff <= amount_in;
      site_ff <= site_in;
      row_ff <= row_in;
      col_ff <= col_in;
      if (pop_d_ff) begin
         site_ff <= s_rd_ff[AW+2*CW-1:2*CW];
         row_ff <= s_rd_ff[2*CW-1:CW];
         col_ff <= s_rd_ff[CW-1:0];
      end
   end

   assign sts.clear_done = clear_done_ff;
   assign sts.stack_empty = (sp_ff == '0);
   assign sts.nb_valid = nb_ok;
   assign sts.amount_zero = (amount_ff == '0);
   assign sts.out_ready = out_ready_ff;
   assign odo_c = odo_c_ff;
   assign odo_d = odo_d_ff;
   assign radius = radius_ff;
   assign border = border_ff;

   // Stack never exceeds the lattice; a clear leaves it empty.
   a_sp_range: assert property (@(posedge clock) disable iff (reset)
      sp_ff <= SW'(CELLS)) else $error("stack overflow");
   a_clear_empty: assert property (@(posedge clock) disable iff (reset)
      clear_done_ff |-> sp_ff == '0) else $error("stack not empty after clear");
   a_border_radius: assert property (@(posedge clock) disable iff (reset)
      $rose(border_ff) |-> radius_ff != '0) else $error("border without radius");
endmodule

// ===== sv/sps_controller.sv =====
// Sequencer for clear sweeps, grain drops and the toppling loop.
module sps_controller (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic [8:0]           req_tdata,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output sps_pkg::ctl_type     ctl,
   input  sps_pkg::sts_type     sts
);
   typedef enum logic [3:0] {
      ST_INIT, ST_IDLE, ST_CLEAR, ST_DROP_RD, ST_DROP_WR, ST_POP, ST_POP_WAIT,
      ST_POP_LOAD, ST_TOPPLE, ST_NB_RD, ST_NB_WR, ST_SELF_RD, ST_SELF_CHK,
      ST_SELF_PUSH, ST_OUT, ST_RESP
   } state_type;

   state_type    state_ff;
   logic [1:0]   sel_ff;
   logic [3:0]   ga_ff, gb_ff;
   logic         rsp_valid_ff;

   // Decode command from state.
   always_comb begin
      ctl.sel = sel_ff;
      ctl.grains = (sel_ff == 2'd0) ? ga_ff : gb_ff;
      case (state_ff)
         ST_INIT, ST_CLEAR: ctl.cmd = sps_pkg::CMD_CLEAR_STEP;
         ST_DROP_RD:  ctl.cmd = sps_pkg::CMD_DROP_READ;
         ST_DROP_WR:  ctl.cmd = sps_pkg::CMD_DROP_WRITE;
         ST_POP:      ctl.cmd = sps_pkg::CMD_POP;
         ST_TOPPLE:   ctl.cmd = sps_pkg::CMD_TOPPLE;
         ST_NB_RD:    ctl.cmd = sps_pkg::CMD_NB_READ;
         ST_NB_WR:    ctl.cmd = sps_pkg::CMD_NB_WRITE;
         ST_SELF_RD, ST_SELF_CHK: ctl.cmd = sps_pkg::CMD_SELF_READ;
         ST_SELF_PUSH: ctl.cmd = sps_pkg::CMD_SELF_PUSH;
         ST_OUT:      ctl.cmd = sps_pkg::CMD_OUT_READ;
         default:     ctl.cmd = sps_pkg::CMD_NONE;
      endcase
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;

   // Step the sequence.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_INIT;
         sel_ff <= 2'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         case (state_ff)
            ST_INIT: if (sts.clear_done) state_ff <= ST_IDLE;
            ST_IDLE: begin
               if (req_tvalid) begin
                  ga_ff <= req_tdata[4:1];
                  gb_ff <= req_tdata[8:5];
                  sel_ff <= 2'd0;
                  if (req_tdata[0] == sps_pkg::ACTION_CLEAR)
                     state_ff <= ST_CLEAR;
                  else if (req_tdata[4:1] != '0)
                     state_ff <= ST_DROP_RD;
                  else if (req_tdata[8:5] != '0) begin
                     sel_ff <= 2'd1;
                     state_ff <= ST_DROP_RD;
                  end else
                     state_ff <= ST_POP_WAIT;
               end
            end
            ST_CLEAR: if (sts.clear_done) state_ff <= ST_OUT;
            ST_DROP_RD: state_ff <= ST_DROP_WR;
            ST_DROP_WR: begin
               if (sel_ff == 2'd0 && gb_ff != '0) begin
                  sel_ff <= 2'd1;
                  state_ff <= ST_DROP_RD;
               end else
                  state_ff <= ST_POP_WAIT;
            end
            // Let push count settle before testing empty.
            ST_POP_WAIT: state_ff <= sts.stack_empty ? ST_OUT : ST_POP;
            // Wait for the popped entry to load before reading its site.
            ST_POP: state_ff <= ST_POP_LOAD;
            ST_POP_LOAD: state_ff <= ST_SELF_RD;
            ST_SELF_RD: state_ff <= ST_TOPPLE;
            ST_TOPPLE: begin
               sel_ff <= 2'd0;
               state_ff <= ST_NB_RD;
            end
            ST_NB_RD: state_ff <= sts.amount_zero ? ST_POP_WAIT : ST_NB_WR;
            ST_NB_WR: begin
               if (sel_ff == 2'd3) state_ff <= ST_SELF_CHK;
               else begin
                  sel_ff <= sel_ff + 2'd1;
                  state_ff <= ST_NB_RD;
               end
            end
            ST_SELF_CHK: state_ff <= ST_SELF_PUSH;
            ST_SELF_PUSH: state_ff <= ST_POP_WAIT;
            ST_OUT: state_ff <= ST_RESP;
            ST_RESP: begin
               if (!rsp_valid_ff) rsp_valid_ff <= 1'b1;
               else if (rsp_tready) begin
                  rsp_valid_ff <= 1'b0;
                  state_ff <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   // Self push reads the popped site again: go via a read.
   a_one_flight: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !req_tready) else $error("request taken with result pending");
   a_rsp_state: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> state_ff == ST_RESP) else $error("result outside response");
   a_clear_ends: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CLEAR && sts.clear_done) |=> state_ff == ST_OUT)
      else $error("clear did not finish");
endmodule
